FILE: hdl/tss_pkg.sv
package tss_pkg;

    localparam int SLOTS         = 16;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int MAX_FRAME_EXP = 10;
    localparam int EXP_W         = 4;
    localparam int ECNT_W        = EXP_W + 1;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [2:0] OPC_TICK   = 3'd0;
    localparam logic [2:0] OPC_TMO    = 3'd1;
    localparam logic [2:0] OPC_IVL    = 3'd2;
    localparam logic [2:0] OPC_FRM    = 3'd3;
    localparam logic [2:0] OPC_CANCEL = 3'd4;

    localparam logic [2:0] K_REG    = 3'd0;
    localparam logic [2:0] K_FULL   = 3'd1;
    localparam logic [2:0] K_BADEXP = 3'd2;
    localparam logic [2:0] K_FTMO   = 3'd3;
    localparam logic [2:0] K_FIVL   = 3'd4;
    localparam logic [2:0] K_FFRM   = 3'd5;
    localparam logic [2:0] K_TICK   = 3'd6;
    localparam logic [2:0] K_CANCEL = 3'd7;

    localparam logic [1:0] TY_TMO = 2'd0;
    localparam logic [1:0] TY_IVL = 2'd1;
    localparam logic [1:0] TY_FRM = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_TMO,
        OP_IVL,
        OP_FRM,
        OP_CAN
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TMO_SCAN,
        ST_TMO_ACT,
        ST_IVL_SCAN,
        ST_IVL_ACT,
        ST_DIV,
        ST_IVL_EMIT,
        ST_FRM_CHK,
        ST_FRM_SCAN,
        ST_FRM_ACT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] time_now;
        logic [31:0] amount;
        logic [31:0] user_tag;
        logic [3:0]  cancel_slot;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] tag_out;
        logic [7:0]  fire_count;
        logic [31:0] elapsed;
        logic [31:0] frame_number;
        logic        last;
    } t_out;

    typedef struct packed {
        t_op op;
        t_in data;
    } t_cmd;

endpackage

FILE: hdl/tss_front.sv
module tss_front import tss_pkg::*; (
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_q_ready,
    output logic o_push,
    output t_cmd o_cmd
);

    logic known;

    always_comb begin
        known = 1'b1;
        o_cmd.data = i_in_data;
        case (i_in_data.opcode)
            OPC_TICK:   o_cmd.op = OP_TICK;
            OPC_TMO:    o_cmd.op = OP_TMO;
            OPC_IVL:    o_cmd.op = OP_IVL;
            OPC_FRM:    o_cmd.op = OP_FRM;
            OPC_CANCEL: o_cmd.op = OP_CAN;
            default: begin
                o_cmd.op = OP_TICK;
                known = 1'b0;
            end
        endcase
    end

    // Items with an unknown opcode are accepted and dropped here.
    assign o_in_ready = i_q_ready;
    assign o_push     = i_in_valid && i_q_ready && known;

endmodule

FILE: hdl/tss_fifo.sv
module tss_fifo import tss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_ready = r_cnt != QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hdl/tss_back.sv
module tss_back import tss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    input  logic        i_cfg_valid,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);

    t_state r_state, n_state;

    logic              r_used  [SLOTS];
    logic              n_used  [SLOTS];
    logic [1:0]        r_type  [SLOTS];
    logic [1:0]        n_type  [SLOTS];
    logic              r_alive [SLOTS];
    logic              n_alive [SLOTS];
    logic [31:0]       r_dl    [SLOTS];
    logic [31:0]       n_dl    [SLOTS];
    logic [31:0]       r_per   [SLOTS];
    logic [31:0]       n_per   [SLOTS];
    logic [EXP_W-1:0]  r_exp   [SLOTS];
    logic [EXP_W-1:0]  n_exp   [SLOTS];
    logic [31:0]       r_tag   [SLOTS];
    logic [31:0]       n_tag   [SLOTS];
    logic [SLOT_W-1:0] r_ord   [SLOTS];
    logic [SLOT_W-1:0] n_ord   [SLOTS];
    logic              r_vis   [SLOTS];
    logic              n_vis   [SLOTS];

    logic [31:0]       r_lft, n_lft;
    logic [31:0]       r_fc, n_fc;
    logic [31:0]       r_now, n_now;
    logic [31:0]       r_el, n_el;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [31:0]       r_best_dl, n_best_dl;
    logic [SLOT_W-1:0] r_best_ord, n_best_ord;
    logic              r_found, n_found;
    logic [ECNT_W-1:0] r_e, n_e;
    logic [32:0]       r_rem, n_rem;
    logic [31:0]       r_quo, n_quo;
    logic [31:0]       r_dvs, n_dvs;
    logic [4:0]        r_dcnt, n_dcnt;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;

    logic              out_free;
    logic              emit;
    t_out              e_val;
    logic              do_free;
    logic [SLOT_W-1:0] rd;
    logic              cand;
    logic              better;
    logic              any_free;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] cs_idx;
    logic              cs_ok;
    logic [32:0]       div_tmp;
    logic              div_ge;
    logic [7:0]        fire_cnt;
    logic [31:0]       amt;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign rd = (r_state inside {ST_TMO_SCAN, ST_IVL_SCAN, ST_FRM_SCAN}) ? r_idx : r_best;
    assign cs_idx = SLOT_W'(i_cmd.data.cancel_slot);
    assign cs_ok  = {28'd0, i_cmd.data.cancel_slot} < 32'(SLOTS);
    assign amt    = i_cmd.data.amount;
    assign div_tmp = {r_rem[31:0], r_quo[31]};
    assign div_ge  = div_tmp >= {1'b0, r_dvs};
    assign fire_cnt = (r_quo >= 32'd255) ? 8'hFF : r_quo[7:0] + 8'd1;

    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_used[j]) begin
                any_free = 1'b1;
                free_idx = SLOT_W'(j);
            end
        end
    end

    always_comb begin
        cand   = 1'b0;
        better = 1'b0;
        case (r_state)
            ST_TMO_SCAN: begin
                cand   = r_used[rd] && r_type[rd] == TY_TMO && r_dl[rd] <= r_now;
                better = !r_found || r_dl[rd] < r_best_dl ||
                         (r_dl[rd] == r_best_dl && r_ord[rd] > r_best_ord);
            end
            ST_IVL_SCAN: begin
                cand   = r_used[rd] && r_type[rd] == TY_IVL && !r_vis[rd];
                better = !r_found || r_ord[rd] < r_best_ord;
            end
            ST_FRM_SCAN: begin
                cand   = r_used[rd] && r_type[rd] == TY_FRM && !r_vis[rd] &&
                         r_exp[rd] == r_e[EXP_W-1:0];
                better = !r_found || r_ord[rd] < r_best_ord;
            end
            default: begin
                cand   = 1'b0;
                better = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_type     = r_type;
        n_alive    = r_alive;
        n_dl       = r_dl;
        n_per      = r_per;
        n_exp      = r_exp;
        n_tag      = r_tag;
        n_ord      = r_ord;
        n_vis      = r_vis;
        n_lft      = r_lft;
        n_fc       = r_fc;
        n_now      = r_now;
        n_el       = r_el;
        n_idx      = r_idx;
        n_best     = r_best;
        n_best_dl  = r_best_dl;
        n_best_ord = r_best_ord;
        n_found    = r_found;
        n_e        = r_e;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dvs      = r_dvs;
        n_dcnt     = r_dcnt;
        o_cmd_pop  = 1'b0;
        emit       = 1'b0;
        do_free    = 1'b0;
        e_val      = '0;
        e_val.frame_number = r_fc;
        e_val.elapsed      = r_el;
        e_val.slot         = 4'(r_best);
        e_val.tag_out      = r_tag[rd];
        e_val.fire_count   = 8'd1;

        if (i_cfg_valid) begin
            n_lft = i_cfg_data;
        end

        if (r_state inside {ST_TMO_SCAN, ST_IVL_SCAN, ST_FRM_SCAN}) begin
            if (cand && better) begin
                n_found    = 1'b1;
                n_best     = r_idx;
                n_best_dl  = r_dl[rd];
                n_best_ord = r_ord[rd];
            end
            n_idx = r_idx + 1'b1;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_TICK: begin
                            o_cmd_pop = 1'b1;
                            n_fc      = r_fc + 32'd1;
                            n_el      = i_cmd.data.time_now - r_lft;
                            n_lft     = i_cmd.data.time_now;
                            n_now     = i_cmd.data.time_now;
                            n_found   = 1'b0;
                            n_idx     = '0;
                            n_state   = ST_TMO_SCAN;
                        end
                        OP_CAN: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                emit      = 1'b1;
                                e_val     = '0;
                                e_val.kind = K_CANCEL;
                                e_val.slot = i_cmd.data.cancel_slot;
                                e_val.frame_number = r_fc;
                                if (cs_ok && r_used[cs_idx]) begin
                                    n_alive[cs_idx] = 1'b0;
                                end
                            end
                        end
                        default: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                emit      = 1'b1;
                                e_val     = '0;
                                e_val.frame_number = r_fc;
                                if (i_cmd.op == OP_FRM && amt > 32'(MAX_FRAME_EXP)) begin
                                    e_val.kind = K_BADEXP;
                                end else if (!any_free) begin
                                    e_val.kind = K_FULL;
                                end else begin
                                    e_val.kind = K_REG;
                                    e_val.slot = 4'(free_idx);
                                    for (int j = 0; j < SLOTS; j++) begin
                                        if (r_used[j]) begin
                                            n_ord[j] = r_ord[j] + 1'b1;
                                        end
                                    end
                                    n_used[free_idx]  = 1'b1;
                                    n_ord[free_idx]   = '0;
                                    n_alive[free_idx] = 1'b1;
                                    n_tag[free_idx]   = i_cmd.data.user_tag;
                                    n_per[free_idx]   = '0;
                                    n_exp[free_idx]   = '0;
                                    case (i_cmd.op)
                                        OP_TMO: begin
                                            n_type[free_idx] = TY_TMO;
                                            n_dl[free_idx] = r_lft +
                                                ((amt != 32'd0) ? amt : 32'd1);
                                        end
                                        OP_IVL: begin
                                            n_type[free_idx] = TY_IVL;
                                            n_dl[free_idx]   = r_lft + amt;
                                            n_per[free_idx]  = amt;
                                        end
                                        default: begin
                                            n_type[free_idx] = TY_FRM;
                                            n_dl[free_idx]   = r_lft;
                                            n_exp[free_idx]  = amt[EXP_W-1:0];
                                        end
                                    endcase
                                end
                            end
                        end
                    endcase
                end
            end
            ST_TMO_SCAN: begin
                if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_idx = '0;
                    if (n_found) begin
                        n_state = ST_TMO_ACT;
                    end else begin
                        for (int j = 0; j < SLOTS; j++) begin
                            n_vis[j] = 1'b0;
                        end
                        n_state = ST_IVL_SCAN;
                    end
                end
            end
            ST_TMO_ACT: begin
                if (!r_alive[rd] || out_free) begin
                    if (r_alive[rd]) begin
                        emit       = 1'b1;
                        e_val.kind = K_FTMO;
                    end
                    do_free = 1'b1;
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = ST_TMO_SCAN;
                end
            end
            ST_IVL_SCAN: begin
                if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_idx = '0;
                    if (n_found) begin
                        n_state = ST_IVL_ACT;
                    end else begin
                        n_e     = '0;
                        n_state = ST_FRM_CHK;
                    end
                end
            end
            ST_IVL_ACT: begin
                n_vis[r_best] = 1'b1;
                if (r_dl[rd] > r_now) begin
                    n_found = 1'b0;
                    n_state = ST_IVL_SCAN;
                end else if (!r_alive[rd]) begin
                    do_free = 1'b1;
                    n_found = 1'b0;
                    n_state = ST_IVL_SCAN;
                end else if (r_per[rd] == 32'd0) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        e_val.kind = K_FIVL;
                        do_free    = 1'b1;
                        n_found    = 1'b0;
                        n_state    = ST_IVL_SCAN;
                    end
                end else begin
                    n_rem   = '0;
                    n_quo   = r_now - r_dl[rd];
                    n_dvs   = r_per[rd];
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = div_ge ? div_tmp - {1'b0, r_dvs} : div_tmp;
                n_quo  = {r_quo[30:0], div_ge};
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = ST_IVL_EMIT;
                end
            end
            ST_IVL_EMIT: begin
                if (out_free) begin
                    emit             = 1'b1;
                    e_val.kind       = K_FIVL;
                    e_val.fire_count = fire_cnt;
                    // Deadline plus (q + 1) periods equals now minus remainder plus period.
                    n_dl[r_best]     = r_now - r_rem[31:0] + r_dvs;
                    n_found          = 1'b0;
                    n_state          = ST_IVL_SCAN;
                end
            end
            ST_FRM_CHK: begin
                if (r_e > ECNT_W'(MAX_FRAME_EXP)) begin
                    n_state = ST_DONE;
                end else if ((r_fc & ((32'd1 << r_e) - 32'd1)) != 32'd0) begin
                    n_e = r_e + 1'b1;
                end else begin
                    for (int j = 0; j < SLOTS; j++) begin
                        n_vis[j] = 1'b0;
                    end
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = ST_FRM_SCAN;
                end
            end
            ST_FRM_SCAN: begin
                if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_idx = '0;
                    if (n_found) begin
                        n_state = ST_FRM_ACT;
                    end else begin
                        n_e     = r_e + 1'b1;
                        n_state = ST_FRM_CHK;
                    end
                end
            end
            ST_FRM_ACT: begin
                n_vis[r_best] = 1'b1;
                if (!r_alive[rd]) begin
                    do_free = 1'b1;
                    n_found = 1'b0;
                    n_state = ST_FRM_SCAN;
                end else if (r_dl[rd] > r_now) begin
                    n_found = 1'b0;
                    n_state = ST_FRM_SCAN;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_val.kind = K_FFRM;
                    n_found    = 1'b0;
                    n_state    = ST_FRM_SCAN;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_val      = '0;
                    e_val.kind = K_TICK;
                    e_val.elapsed      = r_el;
                    e_val.frame_number = r_fc;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_free) begin
            n_used[r_best] = 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                if (r_used[j] && r_ord[j] > r_best_ord) begin
                    n_ord[j] = r_ord[j] - 1'b1;
                end
            end
        end

        // Only the tick done item closes a tick; fire items do not, and every other item is single.
        e_val.last = (e_val.kind != K_FTMO) && (e_val.kind != K_FIVL) &&
                     (e_val.kind != K_FFRM);

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = e_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lft       <= '0;
            r_fc        <= '0;
            for (int j = 0; j < SLOTS; j++) begin
                r_used[j] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lft       <= n_lft;
            r_fc        <= n_fc;
            r_used      <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_alive    <= n_alive;
        r_dl       <= n_dl;
        r_per      <= n_per;
        r_exp      <= n_exp;
        r_tag      <= n_tag;
        r_ord      <= n_ord;
        r_vis      <= n_vis;
        r_now      <= n_now;
        r_el       <= n_el;
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_dl  <= n_best_dl;
        r_best_ord <= n_best_ord;
        r_found    <= n_found;
        r_e        <= n_e;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_dvs      <= n_dvs;
        r_dcnt     <= n_dcnt;
        r_out      <= n_out;
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_dvs != 32'd0)
        else $error("divider running with a zero period");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FRM_SCAN |-> r_e <= ECNT_W'(MAX_FRAME_EXP))
        else $error("frame scan beyond the largest exponent");

    a_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TMO_ACT && n_state == ST_TMO_SCAN) |=> !r_used[$past(r_best)])
        else $error("fired timeout slot still in use");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == ST_IDLE && i_cmd_valid)
        else $error("queue popped outside idle");

endmodule

FILE: hdl/timer_slot_scheduler.sv
// Timer slot scheduler with a table of 16 slots.
// The input channel takes operation items: tick, register timeout, register
// interval, register frame interval and cancel. The output channel returns
// result items, and the last flag marks the final result of each input item.
// The configuration channel loads the time base into the last frame time; it
// is always ready, and the user must write it only while the block is idle,
// which the block does not enforce. A register or cancel item gives one result,
// written to the output register as the back end takes the item from the queue.
// A tick is taken from the queue and then scans the table one slot a cycle: a
// scan and an action step per due timeout plus one more scan, a scan and an
// action step per interval plus one more scan, and for each of the 11 exponents
// a check step, then for an eligible exponent a scan and an action step per
// frame interval plus one more scan; a last step gives the tick done item. A
// catching-up interval adds a long division and an emit step. A two-item queue
// lets input items be accepted while a tick is at work. Reset frees every slot,
// clears the frame count and sets the last frame time to zero. If the receiver
// stalls, the result waits in the output register; the back end holds until taken.
module timer_slot_scheduler import tss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic push;
    logic q_ready;
    logic q_valid;
    logic pop;
    t_cmd f_cmd;
    t_cmd q_cmd;

    assign o_cfg_ready = 1'b1;

    tss_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_ready  (q_ready),
        .o_push     (push),
        .o_cmd      (f_cmd)
    );

    tss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    tss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: dv/tb.sv
module tb;
    import tss_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    timer_slot_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the slot table.
    logic        sh_used  [SLOTS];
    logic [1:0]  sh_type  [SLOTS];
    logic        sh_alive [SLOTS];
    logic [31:0] sh_dead  [SLOTS];
    logic [31:0] sh_per   [SLOTS];
    logic [3:0]  sh_exp   [SLOTS];
    logic [31:0] sh_tag   [SLOTS];
    logic [7:0]  sh_order [SLOTS];
    logic [31:0] sh_last_time;
    logic [31:0] sh_frames;

    t_out result_q[$];
    int   errors = 0;
    int   n_items = 0;

    function automatic void push_result(logic [2:0] k, logic [3:0] s, logic [31:0] tg,
                                        logic [7:0] c, logic [31:0] el);
        t_out r;
        r.kind = k; r.slot = s; r.tag_out = tg; r.fire_count = c;
        r.elapsed = el; r.frame_number = sh_frames; r.last = 1'b0;
        result_q.push_back(r);
    endfunction

    function automatic void release_slot(int s);
        logic [7:0] o;
        o = sh_order[s];
        sh_used[s] = 1'b0;
        for (int j = 0; j < SLOTS; j++)
            if (sh_used[j] && sh_order[j] > o) sh_order[j]--;
    endfunction

    function automatic int newest(logic [1:0] ty, int e, logic [SLOTS-1:0] seen);
        int b;
        b = -1;
        for (int j = 0; j < SLOTS; j++) begin
            if (!sh_used[j] || sh_type[j] != ty || seen[j]) continue;
            if (ty == TY_FRM && sh_exp[j] != e) continue;
            if (b < 0 || sh_order[j] < sh_order[b]) b = j;
        end
        return b;
    endfunction

    function automatic void predict_tick(logic [31:0] now);
        logic [31:0] el;
        logic [SLOTS-1:0] seen;
        logic [63:0] cnt;
        int s;
        sh_frames++;
        el = now - sh_last_time;
        sh_last_time = now;
        forever begin
            s = -1;
            for (int j = 0; j < SLOTS; j++) begin
                if (!sh_used[j] || sh_type[j] != TY_TMO || sh_dead[j] > now) continue;
                if (s < 0 || sh_dead[j] < sh_dead[s] ||
                    (sh_dead[j] == sh_dead[s] && sh_order[j] > sh_order[s])) s = j;
            end
            if (s < 0) break;
            if (sh_alive[s]) push_result(K_FTMO, 4'(s), sh_tag[s], 8'd1, el);
            release_slot(s);
        end
        seen = '0;
        forever begin
            s = newest(TY_IVL, 0, seen);
            if (s < 0) break;
            seen[s] = 1'b1;
            if (sh_dead[s] > now) continue;
            if (!sh_alive[s]) begin
                release_slot(s);
                continue;
            end
            if (sh_per[s] == 0) begin
                push_result(K_FIVL, 4'(s), sh_tag[s], 8'd1, el);
                release_slot(s);
            end else begin
                cnt = 64'(now - sh_dead[s]) / 64'(sh_per[s]) + 64'd1;
                sh_dead[s] = 32'(64'(sh_dead[s]) + cnt * 64'(sh_per[s]));
                push_result(K_FIVL, 4'(s), sh_tag[s], cnt > 255 ? 8'd255 : 8'(cnt), el);
            end
        end
        for (int e = 0; e <= MAX_FRAME_EXP; e++) begin
            if ((sh_frames & ((32'd1 << e) - 1)) != 0) continue;
            seen = '0;
            forever begin
                s = newest(TY_FRM, e, seen);
                if (s < 0) break;
                seen[s] = 1'b1;
                if (!sh_alive[s]) begin
                    release_slot(s);
                    continue;
                end
                if (sh_dead[s] <= now) push_result(K_FFRM, 4'(s), sh_tag[s], 8'd1, el);
            end
        end
        push_result(K_TICK, 0, 0, 0, el);
    endfunction

    function automatic void predict_item(t_in it);
        int s;
        int n0;
        n0 = result_q.size();
        if (it.opcode == OPC_TICK) begin
            predict_tick(it.time_now);
        end else if (it.opcode >= OPC_TMO && it.opcode <= OPC_FRM) begin
            s = -1;
            for (int j = 0; j < SLOTS; j++)
                if (!sh_used[j] && s < 0) s = j;
            if (it.opcode == OPC_FRM && it.amount > MAX_FRAME_EXP) begin
                push_result(K_BADEXP, 0, 0, 0, 0);
            end else if (s < 0) begin
                push_result(K_FULL, 0, 0, 0, 0);
            end else begin
                for (int j = 0; j < SLOTS; j++)
                    if (sh_used[j]) sh_order[j]++;
                sh_used[s] = 1'b1; sh_order[s] = 0; sh_alive[s] = 1'b1;
                sh_tag[s] = it.user_tag; sh_per[s] = 0; sh_exp[s] = 0;
                if (it.opcode == OPC_TMO) begin
                    sh_type[s] = TY_TMO;
                    sh_dead[s] = sh_last_time + (it.amount > 0 ? it.amount : 32'd1);
                end else if (it.opcode == OPC_IVL) begin
                    sh_type[s] = TY_IVL;
                    sh_dead[s] = sh_last_time + it.amount;
                    sh_per[s] = it.amount;
                end else begin
                    sh_type[s] = TY_FRM;
                    sh_dead[s] = sh_last_time;
                    sh_exp[s] = it.amount[3:0];
                end
                push_result(K_REG, 4'(s), 0, 0, 0);
            end
        end else if (it.opcode == OPC_CANCEL) begin
            if (sh_used[it.cancel_slot]) sh_alive[it.cancel_slot] = 1'b0;
            push_result(K_CANCEL, it.cancel_slot, 0, 0, 0);
        end
        if (result_q.size() > n0) result_q[$].last = 1'b1;
    endfunction

    // Entered and left at a falling edge; the caller drops valid after the last item.
    task automatic send_item(t_in it);
        int g;
        g = 0;
        if ($urandom_range(3) == 0) g = $urandom_range(6);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_data <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(it);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_start(logic [31:0] v);
        @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sh_last_time = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in mk(logic [2:0] op, logic [31:0] tn, logic [31:0] am,
                               logic [31:0] tg, logic [3:0] cs);
        t_in it;
        it.opcode = op; it.time_now = tn; it.amount = am; it.user_tag = tg;
        it.cancel_slot = cs;
        return it;
    endfunction

    function automatic t_in rand_item(logic [31:0] base);
        t_in it;
        int r;
        it = mk(3'($urandom), $urandom, $urandom, $urandom, 4'($urandom));
        r = $urandom_range(99);
        if (r < 30) begin
            it.opcode = OPC_TICK;
            if ($urandom_range(9) != 0) it.time_now = base + $urandom_range(400);
        end else if (r < 50) begin
            it.opcode = OPC_TMO;
            if ($urandom_range(7) != 0) it.amount = $urandom_range(300);
        end else if (r < 68) begin
            it.opcode = OPC_IVL;
            if ($urandom_range(7) != 0) it.amount = $urandom_range(120);
        end else if (r < 80) begin
            it.opcode = OPC_FRM;
            if ($urandom_range(5) != 0) it.amount = $urandom_range(MAX_FRAME_EXP);
        end else if (r < 95) begin
            it.opcode = OPC_CANCEL;
        end
        return it;
    endfunction

    always @(negedge i_clk) begin
        if ($urandom_range(9) < 3 && (n_items / 60) % 3 != 1) i_out_ready <= 1'b0;
        else i_out_ready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %p", o_out_data);
            end else begin
                exp_r = result_q.pop_front();
                if (o_out_data !== exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("result item mismatch: expected %p actual %p",
                                 exp_r, o_out_data);
                end
            end
        end
    end

    initial begin
        t_in dir[$];
        t_in it;
        t_out fixed;
        logic [31:0] clock_ms;
        for (int j = 0; j < SLOTS; j++) sh_used[j] = 1'b0;
        sh_last_time = 0;
        sh_frames = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A tick straight after reset has a known result.
        send_item(mk(OPC_TICK, 32'd0, 0, 0, 0));
        fixed = '{kind: K_TICK, slot: 0, tag_out: 0, fire_count: 0, elapsed: 0,
                  frame_number: 1, last: 1'b1};
        if (result_q.size() != 1 || result_q[0] !== fixed) begin
            errors++;
            $display("tick after reset predicted wrongly");
        end
        dir.push_back(mk(OPC_FRM, 0, 32'd11, 32'hFFFF_FFFF, 0));
        dir.push_back(mk(OPC_FRM, 0, 32'hFFFF_FFFF, 0, 0));
        dir.push_back(mk(OPC_TMO, 0, 32'd0, 32'hA, 0));
        dir.push_back(mk(OPC_TMO, 0, 32'd5, 32'hB, 0));
        dir.push_back(mk(OPC_TMO, 0, 32'd5, 32'hC, 0));
        dir.push_back(mk(OPC_TMO, 0, 32'hFFFF_FFFF, 32'hD, 0));
        dir.push_back(mk(OPC_IVL, 0, 32'd0, 32'hE, 0));
        dir.push_back(mk(OPC_IVL, 0, 32'd1, 32'hF, 0));
        dir.push_back(mk(OPC_IVL, 0, 32'd7, 32'h10, 0));
        dir.push_back(mk(OPC_FRM, 0, 32'd0, 32'h11, 0));
        dir.push_back(mk(OPC_FRM, 0, 32'd1, 32'h12, 0));
        dir.push_back(mk(OPC_FRM, 0, MAX_FRAME_EXP, 32'h13, 0));
        dir.push_back(mk(OPC_CANCEL, 0, 0, 0, 4'd3));
        dir.push_back(mk(OPC_CANCEL, 0, 0, 0, 4'd3));
        dir.push_back(mk(OPC_CANCEL, 0, 0, 0, 4'd15));
        dir.push_back(mk(3'd7, 32'hFFFF_FFFF, 0, 0, 0));
        dir.push_back(mk(OPC_TICK, 32'd1000, 0, 0, 0));
        for (int j = 0; j < 8; j++) dir.push_back(mk(OPC_IVL, 0, 32'd50, j, 0));
        dir.push_back(mk(OPC_TMO, 0, 32'd3, 32'h77, 0));
        dir.push_back(mk(OPC_TICK, 32'hFFFF_FFFF, 0, 0, 0));
        foreach (dir[i]) send_item(dir[i]);
        i_in_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: clock_ms = 32'hFFFF_FFFF;
                1: clock_ms = 32'hFFFF_FF00;
                2: clock_ms = 32'd0;
                default: clock_ms = $urandom;
            endcase
            write_start(clock_ms);
            for (int k = 0; k < 110; k++) begin
                it = rand_item(clock_ms);
                if (it.opcode == OPC_TICK && it.time_now - clock_ms < 32'd1000)
                    clock_ms = it.time_now;
                send_item(it);
            end
            i_in_valid <= 1'b0;
            drain();
        end
        if (errors == 0) $display("timer_slot_scheduler: match");
        else $display("timer_slot_scheduler: mismatch");
        $finish;
    end

    initial begin
        #60000000;
        $display("timer_slot_scheduler: mismatch");
        $finish;
    end
endmodule
